/* hdl/cba_pkg.sv */
// Shared types, constants and helper functions for the class budget admission block.
package cba_pkg;

   localparam int NumClasses = 4;
   localparam int ByteWidth  = 32;
   localparam int CntWidth   = 32;
   localparam int ClassIdxW  = $clog2(NumClasses);
   localparam int ClassFldW  = 3;
   localparam int ReqTypeW   = 2;
   localparam int StatusW    = 2;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 32;

   typedef logic [ByteWidth-1:0] bytes_type;
   typedef logic [CntWidth-1:0]  count_type;
   typedef logic [ClassFldW-1:0] class_fld_type;

   typedef enum logic [ReqTypeW-1:0] {
      ReqReserve = 2'd0,
      ReqResize  = 2'd1,
      ReqRelease = 2'd2,
      ReqUnused  = 2'd3
   } req_kind_type;

   typedef enum logic [StatusW-1:0] {
      StGrant   = 2'd0,
      StRefuse  = 2'd1,
      StInvalid = 2'd2
   } status_type;

   // Register index of the global limit; class ceilings follow it in order.
   localparam logic [CsrIdxW-1:0] CsrTotalLimit  = 3'd0;
   localparam int                 CsrCeilingBase = 1;

   typedef struct packed {
      bytes_type                  total_limit;
      bytes_type [NumClasses-1:0] ceiling;
   } limits_type;

   typedef struct packed {
      req_kind_type  kind;
      class_fld_type req_class;
      bytes_type     held_bytes;
      bytes_type     request_bytes;
   } request_type;

   typedef struct packed {
      status_type status;
      bytes_type  lease_bytes;
      bytes_type  total_in_use;
      bytes_type  total_peak;
      count_type  total_refusals;
      bytes_type  class_in_use;
      bytes_type  class_peak;
      count_type  class_refusals;
   } result_type;

   // Headroom left under a limit; zero once usage has reached or passed it.
   function automatic bytes_type room(input bytes_type limit, input bytes_type used);
      return (used >= limit) ? '0 : bytes_type'(limit - used);
   endfunction

   function automatic bytes_type sat_sub(input bytes_type a, input bytes_type b);
      return (b >= a) ? '0 : bytes_type'(a - b);
   endfunction

   function automatic count_type count_up(input count_type c);
      return (c == '1) ? c : count_type'(c + count_type'(1));
   endfunction

endpackage

/* hdl/cba_req_if.sv */
// Request channel: valid/ready handshake with the admission request payload.
interface cba_req_if
   import cba_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ReqTypeW-1:0]  req_type;
   logic [ClassFldW-1:0] req_class;
   logic [ByteWidth-1:0] held_bytes;
   logic [ByteWidth-1:0] request_bytes;

   modport source (output valid, req_type, req_class, held_bytes, request_bytes,
                   input ready);
   modport sink   (input valid, req_type, req_class, held_bytes, request_bytes,
                   output ready);
endinterface

/* hdl/cba_rsp_if.sv */
// Response channel: valid/ready handshake with the admission result payload.
interface cba_rsp_if
   import cba_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [StatusW-1:0]   status;
   logic [ByteWidth-1:0] lease_bytes;
   logic [ByteWidth-1:0] total_in_use;
   logic [ByteWidth-1:0] total_peak;
   logic [CntWidth-1:0]  total_refusals;
   logic [ByteWidth-1:0] class_in_use;
   logic [ByteWidth-1:0] class_peak;
   logic [CntWidth-1:0]  class_refusals;

   modport source (output valid, status, lease_bytes, total_in_use, total_peak,
                          total_refusals, class_in_use, class_peak, class_refusals,
                   input ready);
   modport sink   (input valid, status, lease_bytes, total_in_use, total_peak,
                         total_refusals, class_in_use, class_peak, class_refusals,
                   output ready);
endinterface

/* hdl/cba_csr.sv */
// Configuration registers: global byte limit and one ceiling per class.
module cba_csr
   import cba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output limits_type          limits
);

   limits_type limits_ff;
   limits_type limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (csr_wr_en) begin
         if (csr_index == CsrTotalLimit) begin
            limits_in.total_limit = bytes_type'(csr_wdata);
         end
         for (int i = 0; i < NumClasses; i++) begin
            if (csr_index == CsrIdxW'(CsrCeilingBase + i)) begin
               limits_in.ceiling[i] = bytes_type'(csr_wdata);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.total_limit <= '1;
         for (int i = 0; i < NumClasses; i++) begin
            limits_ff.ceiling[i] <= '1;
         end
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

/* hdl/cba_ledger.sv */
// Usage ledger: admission decision, usage totals, peak marks and refusal counters.
module cba_ledger
   import cba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  request_type req,
   input  limits_type  limits,
   output result_type  result
);

   bytes_type total_used_ff, total_used_in;
   bytes_type total_mark_ff, total_mark_in;
   count_type total_refused_ff, total_refused_in;
   bytes_type class_used_ff    [NumClasses];
   bytes_type class_mark_ff    [NumClasses];
   count_type class_refused_ff [NumClasses];
   bytes_type class_used_in, class_mark_in;
   count_type class_refused_in;

   logic                 cls_ok;
   logic [ClassIdxW-1:0] k;
   logic                 grow;
   bytes_type            amount;
   bytes_type            give;
   logic                 fits;

   assign cls_ok = (req.req_class < ClassFldW'(NumClasses));
   assign k      = req.req_class[ClassIdxW-1:0];
   assign grow   = (req.request_bytes > req.held_bytes);
   assign amount = (req.kind == ReqReserve) ? req.request_bytes
                                            : bytes_type'(req.request_bytes - req.held_bytes);
   assign give   = (req.kind == ReqRelease) ? req.held_bytes
                                            : bytes_type'(req.held_bytes - req.request_bytes);
   assign fits   = (amount <= room(limits.ceiling[k], class_used_ff[k])) &&
                   (amount <= room(limits.total_limit, total_used_ff));

   always_comb begin
      total_used_in    = total_used_ff;
      total_refused_in = total_refused_ff;
      class_used_in    = class_used_ff[k];
      class_mark_in    = class_mark_ff[k];
      class_refused_in = class_refused_ff[k];
      result.status      = StInvalid;
      result.lease_bytes = (req.kind == ReqResize || req.kind == ReqUnused) ?
                           req.held_bytes : '0;

      unique case (req.kind)
         ReqReserve, ReqResize: begin
            if (cls_ok) begin
               if (req.kind == ReqReserve || grow) begin
                  if (fits) begin
                     total_used_in      = bytes_type'(total_used_ff + amount);
                     class_used_in      = bytes_type'(class_used_ff[k] + amount);
                     result.status      = StGrant;
                     result.lease_bytes = req.request_bytes;
                  end else begin
                     total_refused_in = count_up(total_refused_ff);
                     class_refused_in = count_up(class_refused_ff[k]);
                     result.status    = StRefuse;
                  end
               end else begin
                  total_used_in      = sat_sub(total_used_ff, give);
                  class_used_in      = sat_sub(class_used_ff[k], give);
                  result.status      = StGrant;
                  result.lease_bytes = req.request_bytes;
               end
            end
         end
         ReqRelease: begin
            if (cls_ok) begin
               total_used_in = sat_sub(total_used_ff, give);
               class_used_in = sat_sub(class_used_ff[k], give);
               result.status = StGrant;
            end
         end
         ReqUnused: begin
         end
      endcase

      // Usage only falls on a give-back, so the marks can be compared every time.
      total_mark_in = (total_used_in > total_mark_ff) ? total_used_in : total_mark_ff;
      if (class_used_in > class_mark_in) begin
         class_mark_in = class_used_in;
      end

      result.total_in_use   = total_used_in;
      result.total_peak     = total_mark_in;
      result.total_refusals = total_refused_in;
      result.class_in_use   = cls_ok ? class_used_in    : '0;
      result.class_peak     = cls_ok ? class_mark_in    : '0;
      result.class_refusals = cls_ok ? class_refused_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_used_ff    <= '0;
         total_mark_ff    <= '0;
         total_refused_ff <= '0;
         for (int i = 0; i < NumClasses; i++) begin
            class_used_ff[i]    <= '0;
            class_mark_ff[i]    <= '0;
            class_refused_ff[i] <= '0;
         end
      end else if (fire) begin
         total_used_ff    <= total_used_in;
         total_mark_ff    <= total_mark_in;
         total_refused_ff <= total_refused_in;
         if (cls_ok) begin
            class_used_ff[k]    <= class_used_in;
            class_mark_ff[k]    <= class_mark_in;
            class_refused_ff[k] <= class_refused_in;
         end
      end
   end

endmodule

/* hdl/class_budget_admission_core.sv */
// Top level of the class budget admission block: request and result registers around the ledger.
// An accepted request is held in the request register while the ledger decides it; its result
// then moves into the result register, which drives the rsp channel, once that register is free.
// Throughput: one transaction per cycle unless rsp stalls; the ledger updates its counters
// in the same cycle it decides, so back-to-back requests always see the state the last one left.
// Reset (synchronous, active high) empties both registers, zeroes all usage, peak and refusal
// counters, and sets the global limit and every class ceiling to all ones.
module class_budget_admission_core
   import cba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   cba_req_if.sink             req_if,
   cba_rsp_if.source           rsp_if,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   request_type in_req_ff, in_req_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff, out_res_in;

   logic        advance;
   logic        req_fire;
   limits_type  limits;
   result_type  result;

   assign advance  = !out_valid_ff || rsp_if.ready;
   assign req_fire = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      in_req_in    = in_req_ff;
      in_valid_in  = in_valid_ff;
      out_res_in   = out_res_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_res_in = result;
         end
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in             = 1'b1;
         in_req_in.kind          = req_kind_type'(req_if.req_type);
         in_req_in.req_class     = req_if.req_class;
         in_req_in.held_bytes    = req_if.held_bytes;
         in_req_in.request_bytes = req_if.request_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_req_ff  <= in_req_in;
      out_res_ff <= out_res_in;
   end

   cba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   cba_ledger u_ledger (
      .clock  (clock),
      .reset  (reset),
      .fire   (in_valid_ff && advance),
      .req    (in_req_ff),
      .limits (limits),
      .result (result)
   );

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.status         = out_res_ff.status;
   assign rsp_if.lease_bytes    = out_res_ff.lease_bytes;
   assign rsp_if.total_in_use   = out_res_ff.total_in_use;
   assign rsp_if.total_peak     = out_res_ff.total_peak;
   assign rsp_if.total_refusals = out_res_ff.total_refusals;
   assign rsp_if.class_in_use   = out_res_ff.class_in_use;
   assign rsp_if.class_peak     = out_res_ff.class_peak;
   assign rsp_if.class_refusals = out_res_ff.class_refusals;

endmodule

/* hdl/cba_checker.sv */
// Port-level assertions for the admission core and the bind that attaches them.
module cba_checker
   import cba_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [StatusW-1:0]   rsp_status,
   input logic [ByteWidth-1:0] rsp_total_in_use,
   input logic [ByteWidth-1:0] rsp_total_peak,
   input logic [CntWidth-1:0]  rsp_total_refusals,
   input logic [ByteWidth-1:0] rsp_class_in_use,
   input logic [ByteWidth-1:0] rsp_class_peak,
   input logic [CntWidth-1:0]  rsp_class_refusals
);

   // A stalled transaction keeps its status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   a_total_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_peak >= rsp_total_in_use)
      else $error("total peak below total usage");

   a_class_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class_peak >= rsp_class_in_use)
      else $error("class peak below class usage");

   // A refusal has always been counted in both counters by the time it is reported.
   a_refuse_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StRefuse |->
         rsp_total_refusals != '0 && rsp_class_refusals != '0)
      else $error("refusal reported without a count");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind class_budget_admission_core cba_checker u_cba_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_total_in_use   (rsp_if.total_in_use),
   .rsp_total_peak     (rsp_if.total_peak),
   .rsp_total_refusals (rsp_if.total_refusals),
   .rsp_class_in_use   (rsp_if.class_in_use),
   .rsp_class_peak     (rsp_if.class_peak),
   .rsp_class_refusals (rsp_if.class_refusals)
);

/* tb/admission_ledger_check.sv */
// Scoreboard for the class budget admission block: predicts each result and compares it.
`timescale 1ns / 1ps

module admission_ledger_check
   import cba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   cba_req_if                  req_mon,
   cba_rsp_if                  rsp_mon,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int unsigned         mismatch_count,
   output int unsigned         results_due
);

   // Shadow copy of the limits and of the ledger counters.
   bytes_type limit_total;
   bytes_type ceil_cls [NumClasses];
   bytes_type used_total;
   bytes_type mark_total;
   count_type refused_total;
   bytes_type used_cls [NumClasses];
   bytes_type mark_cls [NumClasses];
   count_type refused_cls [NumClasses];

   result_type expected_results [$];

   // Adds amount to class k if both the class and the global headroom cover it.
   function automatic logic grow_usage(int unsigned k, bytes_type amount);
      bytes_type cls_room;
      bytes_type tot_room;
      cls_room = (used_cls[k] >= ceil_cls[k]) ? '0 : ceil_cls[k] - used_cls[k];
      tot_room = (used_total >= limit_total) ? '0 : limit_total - used_total;
      if (amount > cls_room || amount > tot_room) begin
         if (refused_total != '1) refused_total = refused_total + 1'b1;
         if (refused_cls[k] != '1) refused_cls[k] = refused_cls[k] + 1'b1;
         return 1'b0;
      end
      used_total  = used_total + amount;
      used_cls[k] = used_cls[k] + amount;
      if (used_total > mark_total) mark_total = used_total;
      if (used_cls[k] > mark_cls[k]) mark_cls[k] = used_cls[k];
      return 1'b1;
   endfunction

   function automatic void shrink_usage(int unsigned k, bytes_type amount);
      used_total  = (amount >= used_total) ? '0 : used_total - amount;
      used_cls[k] = (amount >= used_cls[k]) ? '0 : used_cls[k] - amount;
   endfunction

   function automatic result_type admit_request(request_type rq);
      result_type  r;
      logic        cls_ok;
      int unsigned k;
      cls_ok = rq.req_class < NumClasses;
      k = cls_ok ? int'(rq.req_class) : 0;
      r = '0;
      r.status = StInvalid;
      case (rq.kind)
         ReqReserve: begin
            if (cls_ok) begin
               if (grow_usage(k, rq.request_bytes)) begin
                  r.status = StGrant;
                  r.lease_bytes = rq.request_bytes;
               end else begin
                  r.status = StRefuse;
               end
            end
         end
         ReqResize: begin
            r.lease_bytes = rq.held_bytes;
            if (cls_ok) begin
               if (rq.request_bytes > rq.held_bytes) begin
                  // Only the growth is checked against the headroom.
                  if (grow_usage(k, rq.request_bytes - rq.held_bytes)) begin
                     r.status = StGrant;
                     r.lease_bytes = rq.request_bytes;
                  end else begin
                     r.status = StRefuse;
                  end
               end else begin
                  shrink_usage(k, rq.held_bytes - rq.request_bytes);
                  r.status = StGrant;
                  r.lease_bytes = rq.request_bytes;
               end
            end
         end
         ReqRelease: begin
            if (cls_ok) begin
               shrink_usage(k, rq.held_bytes);
               r.status = StGrant;
            end
         end
         default: begin
            r.lease_bytes = rq.held_bytes;
         end
      endcase
      r.total_in_use   = used_total;
      r.total_peak     = mark_total;
      r.total_refusals = refused_total;
      if (cls_ok) begin
         r.class_in_use   = used_cls[k];
         r.class_peak     = mark_cls[k];
         r.class_refusals = refused_cls[k];
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      request_type rq;
      result_type  want;
      if (reset) begin
         limit_total   = '1;
         used_total    = '0;
         mark_total    = '0;
         refused_total = '0;
         for (int i = 0; i < NumClasses; i++) begin
            ceil_cls[i]    = '1;
            used_cls[i]    = '0;
            mark_cls[i]    = '0;
            refused_cls[i] = '0;
         end
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CsrTotalLimit) begin
               limit_total = csr_wdata;
            end else if (csr_index < CsrCeilingBase + NumClasses) begin
               ceil_cls[csr_index - CsrCeilingBase] = csr_wdata;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rq.kind          = req_kind_type'(req_mon.req_type);
            rq.req_class     = req_mon.req_class;
            rq.held_bytes    = req_mon.held_bytes;
            rq.request_bytes = req_mon.request_bytes;
            expected_results.push_back(admit_request(rq));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: result transaction arrived with none expected", $time);
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               check_field("lease_bytes", want.lease_bytes, rsp_mon.lease_bytes);
               check_field("total_in_use", want.total_in_use, rsp_mon.total_in_use);
               check_field("total_peak", want.total_peak, rsp_mon.total_peak);
               check_field("total_refusals", want.total_refusals, rsp_mon.total_refusals);
               check_field("class_in_use", want.class_in_use, rsp_mon.class_in_use);
               check_field("class_peak", want.class_peak, rsp_mon.class_peak);
               check_field("class_refusals", want.class_refusals, rsp_mon.class_refusals);
            end
         end
      end
      results_due = expected_results.size();
   end

endmodule

/* tb/class_budget_admission_core_test.sv */
// Top of the class budget admission testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module class_budget_admission_core_test;
   import cba_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int          HoldCycles = 300;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned results_due;
   int unsigned cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_trigger = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_left = 0;

   cba_req_if req_ch ();
   cba_rsp_if rsp_ch ();

   class_budget_admission_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   admission_ledger_check ledger_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (hold_trigger && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic request_type make_req(req_kind_type kind, int cls,
                                            bytes_type held, bytes_type asked);
      request_type rq;
      rq.kind          = kind;
      rq.req_class     = class_fld_type'(cls);
      rq.held_bytes    = held;
      rq.request_bytes = asked;
      return rq;
   endfunction

   function automatic bytes_type pick_bytes();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return $urandom_range(3000);
      endcase
   endfunction

   function automatic request_type random_request();
      int unsigned roll;
      int          cls;
      req_kind_type kind;
      roll = $urandom_range(99);
      if (roll < 40)      kind = ReqReserve;
      else if (roll < 70) kind = ReqResize;
      else if (roll < 95) kind = ReqRelease;
      else                kind = ReqUnused;
      cls = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(NumClasses - 1);
      return make_req(kind, cls, pick_bytes(), pick_bytes());
   endfunction

   // Starts and ends at a falling edge; valid stays high for a following transaction.
   task automatic send_request(request_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= rq.kind;
      req_ch.req_class     <= rq.req_class;
      req_ch.held_bytes    <= rq.held_bytes;
      req_ch.request_bytes <= rq.request_bytes;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_limits(bytes_type total, bytes_type c0, bytes_type c1,
                              bytes_type c2, bytes_type c3);
      bytes_type values [5];
      values = '{total, c0, c1, c2, c3};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= (i == 0) ? CsrTotalLimit : CsrIdxW'(CsrCeilingBase + i - 1);
         csr_wdata <= values[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = '0;
      req_ch.req_class     = '0;
      req_ch.held_bytes    = '0;
      req_ch.request_bytes = '0;
      rsp_ch.ready         = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset limits: extremes, saturation and invalid classes.
      send_request(make_req(ReqReserve, 0, 0, 0));
      send_request(make_req(ReqReserve, 0, 0, '1));
      send_request(make_req(ReqReserve, 1, 0, 1));
      send_request(make_req(ReqResize, 0, '1, 10));
      send_request(make_req(ReqResize, 0, 10, 20));
      send_request(make_req(ReqRelease, 0, 100, 0));
      send_request(make_req(ReqReserve, 7, 0, 5));
      send_request(make_req(ReqResize, 4, 9, 3));
      send_request(make_req(ReqRelease, 5, 8, 0));
      send_request(make_req(ReqUnused, 2, 7, 3));
      send_request(make_req(ReqUnused, 6, 7, 3));
      send_request(make_req(ReqReserve, 3, 0, 1000));
      send_request(make_req(ReqReserve, 2, 0, 500));
      send_request(make_req(ReqResize, 2, 500, 500));
      drain();

      // Tight limits below the current usage, so the headroom is clamped at zero.
      load_limits(1200, 0, 100, '1, 50);
      send_request(make_req(ReqReserve, 0, 0, 0));
      send_request(make_req(ReqReserve, 0, 0, 1));
      send_request(make_req(ReqReserve, 1, 0, 100));
      send_request(make_req(ReqRelease, 3, 1000, 0));
      send_request(make_req(ReqReserve, 1, 0, 100));
      send_request(make_req(ReqReserve, 1, 0, 1));
      send_request(make_req(ReqResize, 3, 0, 51));
      send_request(make_req(ReqResize, 3, 0, 50));
      send_request(make_req(ReqReserve, 2, 0, 550));
      send_request(make_req(ReqReserve, 2, 0, 1));

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 46;
               load_limits(4000 + $urandom_range(4000), $urandom_range(500, 3000),
                           $urandom_range(500, 3000), '1, $urandom_range(1500));
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 12;
               load_limits('1, '0, '1, $urandom, $urandom_range(1000, 8000));
            end
            2: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               load_limits($urandom_range(2000, 10000), '1, $urandom_range(3000),
                           $urandom_range(3000), '0);
               // The long result stall lets the block fill up and push back on requests.
               hold_trigger = 1'b1;
            end
            default: begin
               load_limits('0, $urandom, $urandom_range(3000), '1, $urandom_range(3000));
            end
         endcase
         repeat ((phase == 3) ? 40 : 220) send_request(random_request());
      end
      drain();

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
